[sv/otq_pkg.sv]
`default_nettype none

package otq_pkg;

    // Field widths
    localparam int TW  = 48;  // millisecond tick / expiry
    localparam int IDW = 32;  // timer id
    localparam int DW  = 32;  // delay
    localparam int FW  = 2;   // operation code
    localparam int STW = 2;   // status code
    localparam int SLW = 49;  // signed sleep time

    // Operation codes
    localparam logic [FW-1:0] FN_ADD    = 2'd0;
    localparam logic [FW-1:0] FN_DELETE = 2'd1;
    localparam logic [FW-1:0] FN_CHECK  = 2'd2;

    // Status codes
    localparam logic [STW-1:0] ST_DONE = 2'd0;
    localparam logic [STW-1:0] ST_MISS = 2'd1;
    localparam logic [STW-1:0] ST_FULL = 2'd2;

    // Sleep time reported for an empty table (-1)
    localparam logic [SLW-1:0] SLEEP_EMPTY = {SLW{1'b1}};

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN_OP,
        S_APPLY,
        S_SCAN_MIN,
        S_REPORT
    } t_state;

    // Outcome of one (expiry, id) comparison: eq = same key, lt = a orders first
    typedef struct packed {
        logic eq;
        logic lt;
    } t_cmp;

endpackage

`default_nettype wire

[sv/otq_cmp.sv]
`default_nettype none

// Key comparator shared by every scan: orders by expiry, then by id.
module otq_cmp (
    input  wire logic [otq_pkg::TW-1:0]  i_a_exp,
    input  wire logic [otq_pkg::IDW-1:0] i_a_id,
    input  wire logic [otq_pkg::TW-1:0]  i_b_exp,
    input  wire logic [otq_pkg::IDW-1:0] i_b_id,
    output otq_pkg::t_cmp                o_res
);

    logic w_exp_eq;
    logic w_exp_lt;

    assign w_exp_eq  = (i_a_exp == i_b_exp);
    assign w_exp_lt  = (i_a_exp < i_b_exp);
    assign o_res.eq  = w_exp_eq && (i_a_id == i_b_id);
    assign o_res.lt  = w_exp_lt || (w_exp_eq && (i_a_id < i_b_id));

endmodule

`default_nettype wire

[sv/otq_store.sv]
`default_nettype none

// Timer slot storage: expiry/id memory with a registered read port and
// per-slot valid flags in flops.
module otq_store #(
    parameter int SLOTS = 16,
    parameter int IW    = 4
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_wr_en,
    input  wire logic [IW-1:0]            i_wr_addr,
    input  wire logic [otq_pkg::TW-1:0]   i_wr_exp,
    input  wire logic [otq_pkg::IDW-1:0]  i_wr_id,
    input  wire logic                     i_clr_en,
    input  wire logic [IW-1:0]            i_clr_addr,
    input  wire logic [IW-1:0]            i_rd_addr,
    output logic      [otq_pkg::TW-1:0]   o_rd_exp,
    output logic      [otq_pkg::IDW-1:0]  o_rd_id,
    output logic      [SLOTS-1:0]         o_valid
);

    logic [otq_pkg::TW-1:0]  r_mem_exp [SLOTS];
    logic [otq_pkg::IDW-1:0] r_mem_id  [SLOTS];
    logic [SLOTS-1:0]        r_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem_exp[i_wr_addr] <= i_wr_exp;
            r_mem_id[i_wr_addr]  <= i_wr_id;
        end
        o_rd_exp <= r_mem_exp[i_rd_addr];
        o_rd_id  <= r_mem_id[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_clr_en) begin
                r_valid[i_clr_addr] <= 1'b0;
            end
        end
    end

    assign o_valid = r_valid;

endmodule

`default_nettype wire

[sv/ordered_timer_queue.sv]
`default_nettype none

// Ordered timer queue. Holds up to TIMER_SLOTS pending timers keyed by
// (expiry, id). Each input transfer carries the current tick and an operation:
// add (store a timer expiring at now + delay, saturated at 2^48-1, under the
// next id), delete (remove the timer whose expiry and id both match) or check
// (pop the earliest timer if due). Every operation yields exactly one result
// transfer with a status, the id/expiry of the added or fired timer, and the
// sleep time to the earliest remaining expiry (-1 when empty, 0 when due).
// From acceptance until the result is presented, the slot memory is walked
// twice through its single read port, one slot per cycle, with one shared
// key comparator: the first walk finds the match, free slot or earliest
// entry, the second finds the new earliest entry for the sleep time. o_stall
// is high while an item is in work. A finished result sits in the output
// register, so the next item can be accepted while it waits; only the
// following result waits on it.
module ordered_timer_queue #(
    parameter int TIMER_SLOTS = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // Input channel
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic [otq_pkg::FW-1:0]        i_func,
    input  wire logic [otq_pkg::TW-1:0]        i_now_ms,
    input  wire logic [otq_pkg::DW-1:0]        i_delay_ms,
    input  wire logic [otq_pkg::IDW-1:0]       i_target_id,
    input  wire logic [otq_pkg::TW-1:0]        i_target_expire,
    // Result channel
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic      [otq_pkg::STW-1:0]       o_status,
    output logic      [otq_pkg::IDW-1:0]       o_timer_id,
    output logic      [otq_pkg::TW-1:0]        o_expire_ms,
    output logic signed [otq_pkg::SLW-1:0]     o_sleep_ms
);

    localparam int IW = $clog2(TIMER_SLOTS);
    localparam int CW = IW + 1;
    localparam logic [CW-1:0] SLOT_END = CW'(TIMER_SLOTS);

    // Sequencer state
    otq_pkg::t_state r_state, n_state;

    // Latched item
    logic [otq_pkg::FW-1:0]  r_func, n_func;
    logic [otq_pkg::TW-1:0]  r_now, n_now;

    // Reference key: new timer (add), target (delete), running best (check/min)
    logic [otq_pkg::TW-1:0]  r_ref_exp, n_ref_exp;
    logic [otq_pkg::IDW-1:0] r_ref_id, n_ref_id;
    logic                    r_found, n_found;
    logic [IW-1:0]           r_hit_slot, n_hit_slot;
    logic                    r_free_found, n_free_found;
    logic [IW-1:0]           r_free_slot, n_free_slot;

    // Scan pipeline
    logic [CW-1:0]           r_addr, n_addr;
    logic                    r_pend, n_pend;
    logic [IW-1:0]           r_pend_slot, n_pend_slot;

    logic [otq_pkg::IDW-1:0] r_next_id, n_next_id;

    // Operation result held across the second walk
    logic [otq_pkg::STW-1:0] r_res_status, n_res_status;
    logic [otq_pkg::IDW-1:0] r_res_id, n_res_id;
    logic [otq_pkg::TW-1:0]  r_res_exp, n_res_exp;

    // Output register
    logic                    r_out_valid, n_out_valid;
    logic [otq_pkg::STW-1:0] r_out_status, n_out_status;
    logic [otq_pkg::IDW-1:0] r_out_id, n_out_id;
    logic [otq_pkg::TW-1:0]  r_out_exp, n_out_exp;
    logic [otq_pkg::SLW-1:0] r_out_sleep, n_out_sleep;

    // Store interface
    logic                    w_wr_en;
    logic                    w_clr_en;
    logic [IW-1:0]           w_clr_addr;
    logic [IW-1:0]           w_rd_addr;
    logic [otq_pkg::TW-1:0]  w_rd_exp;
    logic [otq_pkg::IDW-1:0] w_rd_id;
    logic [TIMER_SLOTS-1:0]  w_valid;

    otq_pkg::t_cmp           w_cmp;
    logic [otq_pkg::TW:0]    w_sum;
    logic [otq_pkg::TW-1:0]  w_exp_new;
    logic [otq_pkg::SLW-1:0] w_diff;
    logic                    w_due;
    logic                    w_issue;
    logic                    w_ent_valid;
    logic                    w_accept;

    otq_store #(
        .SLOTS (TIMER_SLOTS),
        .IW    (IW)
    ) u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (w_wr_en),
        .i_wr_addr  (r_free_slot),
        .i_wr_exp   (r_ref_exp),
        .i_wr_id    (r_ref_id),
        .i_clr_en   (w_clr_en),
        .i_clr_addr (w_clr_addr),
        .i_rd_addr  (w_rd_addr),
        .o_rd_exp   (w_rd_exp),
        .o_rd_id    (w_rd_id),
        .o_valid    (w_valid)
    );

    // Entry just read against the reference key
    otq_cmp u_cmp (
        .i_a_exp (w_rd_exp),
        .i_a_id  (w_rd_id),
        .i_b_exp (r_ref_exp),
        .i_b_id  (r_ref_id),
        .o_res   (w_cmp)
    );

    // Saturating expiry for add
    assign w_sum     = {1'b0, i_now_ms} + {{(otq_pkg::TW + 1 - otq_pkg::DW){1'b0}}, i_delay_ms};
    assign w_exp_new = w_sum[otq_pkg::TW] ? {otq_pkg::TW{1'b1}} : w_sum[otq_pkg::TW-1:0];

    // Reference expiry minus now: sign or zero means due; else the sleep time
    assign w_diff = {1'b0, r_ref_exp} - {1'b0, r_now};
    assign w_due  = w_diff[otq_pkg::SLW-1] || (w_diff == '0);

    assign w_issue     = (r_addr < SLOT_END);
    assign w_rd_addr   = r_addr[IW-1:0];
    assign w_ent_valid = w_valid[r_pend_slot];

    assign o_stall  = (r_state != otq_pkg::S_IDLE);
    assign w_accept = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= otq_pkg::S_IDLE;
            r_out_valid <= 1'b0;
            r_next_id   <= '0;
            r_pend      <= 1'b0;
            r_addr      <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_next_id   <= n_next_id;
            r_pend      <= n_pend;
            r_addr      <= n_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func       <= n_func;
        r_now        <= n_now;
        r_ref_exp    <= n_ref_exp;
        r_ref_id     <= n_ref_id;
        r_found      <= n_found;
        r_hit_slot   <= n_hit_slot;
        r_free_found <= n_free_found;
        r_free_slot  <= n_free_slot;
        r_pend_slot  <= n_pend_slot;
        r_res_status <= n_res_status;
        r_res_id     <= n_res_id;
        r_res_exp    <= n_res_exp;
        r_out_status <= n_out_status;
        r_out_id     <= n_out_id;
        r_out_exp    <= n_out_exp;
        r_out_sleep  <= n_out_sleep;
    end

    always_comb begin
        n_state      = r_state;
        n_func       = r_func;
        n_now        = r_now;
        n_ref_exp    = r_ref_exp;
        n_ref_id     = r_ref_id;
        n_found      = r_found;
        n_hit_slot   = r_hit_slot;
        n_free_found = r_free_found;
        n_free_slot  = r_free_slot;
        n_addr       = r_addr;
        n_pend       = r_pend;
        n_pend_slot  = r_pend_slot;
        n_next_id    = r_next_id;
        n_res_status = r_res_status;
        n_res_id     = r_res_id;
        n_res_exp    = r_res_exp;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_id     = r_out_id;
        n_out_exp    = r_out_exp;
        n_out_sleep  = r_out_sleep;
        w_wr_en      = 1'b0;
        w_clr_en     = 1'b0;
        w_clr_addr   = r_hit_slot;

        // Drop the held result once the consumer takes it
        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            otq_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_func       = i_func;
                    n_now        = i_now_ms;
                    n_found      = 1'b0;
                    n_free_found = 1'b0;
                    n_addr       = '0;
                    n_pend       = 1'b0;
                    if (i_func == otq_pkg::FN_ADD) begin
                        n_ref_exp = w_exp_new;
                        n_ref_id  = r_next_id + 1'b1;
                    end else begin
                        n_ref_exp = i_target_expire;
                        n_ref_id  = i_target_id;
                    end
                    n_state = otq_pkg::S_SCAN_OP;
                end
            end

            otq_pkg::S_SCAN_OP, otq_pkg::S_SCAN_MIN: begin
                // Issue one slot read a cycle, evaluate it the cycle after
                if (w_issue) begin
                    n_addr      = r_addr + 1'b1;
                    n_pend      = 1'b1;
                    n_pend_slot = r_addr[IW-1:0];
                end else begin
                    n_pend = 1'b0;
                end

                if (r_pend && w_ent_valid) begin
                    if (r_state == otq_pkg::S_SCAN_MIN || r_func == otq_pkg::FN_CHECK) begin
                        // Track the earliest entry
                        if (!r_found || w_cmp.lt) begin
                            n_found    = 1'b1;
                            n_ref_exp  = w_rd_exp;
                            n_ref_id   = w_rd_id;
                            n_hit_slot = r_pend_slot;
                        end
                    end else if (r_func inside {otq_pkg::FN_ADD, otq_pkg::FN_DELETE}) begin
                        // Look for an exact key match
                        if (w_cmp.eq) begin
                            n_found    = 1'b1;
                            n_hit_slot = r_pend_slot;
                        end
                    end
                end

                // First free slot, used by add
                if (r_pend && !w_ent_valid && !r_free_found) begin
                    n_free_found = 1'b1;
                    n_free_slot  = r_pend_slot;
                end

                if (!w_issue && !r_pend) begin
                    n_state = (r_state == otq_pkg::S_SCAN_OP) ? otq_pkg::S_APPLY
                                                              : otq_pkg::S_REPORT;
                end
            end

            otq_pkg::S_APPLY: begin
                n_res_status = otq_pkg::ST_MISS;
                n_res_id     = '0;
                n_res_exp    = '0;
                case (r_func)
                    otq_pkg::FN_ADD: begin
                        if (r_found) begin
                            // Same key already pending: consume the id, store nothing
                            n_next_id    = r_ref_id;
                            n_res_status = otq_pkg::ST_DONE;
                            n_res_id     = r_ref_id;
                            n_res_exp    = r_ref_exp;
                        end else if (!r_free_found) begin
                            n_res_status = otq_pkg::ST_FULL;
                        end else begin
                            w_wr_en      = 1'b1;
                            n_next_id    = r_ref_id;
                            n_res_status = otq_pkg::ST_DONE;
                            n_res_id     = r_ref_id;
                            n_res_exp    = r_ref_exp;
                        end
                    end
                    otq_pkg::FN_DELETE: begin
                        if (r_found) begin
                            w_clr_en     = 1'b1;
                            n_res_status = otq_pkg::ST_DONE;
                        end
                    end
                    otq_pkg::FN_CHECK: begin
                        // Pop the earliest only if it is due
                        if (r_found && w_due) begin
                            w_clr_en     = 1'b1;
                            n_res_status = otq_pkg::ST_DONE;
                            n_res_id     = r_ref_id;
                            n_res_exp    = r_ref_exp;
                        end
                    end
                    default: begin
                    end
                endcase
                n_found = 1'b0;
                n_addr  = '0;
                n_pend  = 1'b0;
                n_state = otq_pkg::S_SCAN_MIN;
            end

            otq_pkg::S_REPORT: begin
                // Hold until the output register is free
                if (!r_out_valid || !i_stall) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_id     = r_res_id;
                    n_out_exp    = r_res_exp;
                    if (!r_found) begin
                        n_out_sleep = otq_pkg::SLEEP_EMPTY;
                    end else if (w_due) begin
                        n_out_sleep = '0;
                    end else begin
                        n_out_sleep = w_diff;
                    end
                    n_state = otq_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = otq_pkg::S_IDLE;
            end
        endcase
    end

    assign o_valid     = r_out_valid;
    assign o_status    = r_out_status;
    assign o_timer_id  = r_out_id;
    assign o_expire_ms = r_out_exp;
    assign o_sleep_ms  = r_out_sleep;

endmodule

`default_nettype wire

[test/tb_ordered_timer_queue.sv]
`default_nettype none

// Testbench for ordered_timer_queue.
// A scripted opening walks the table extremes: the empty table, expiry
// saturation, delete misses and hits, a full table, (expiry, id) ordering and
// the due/not-due boundary. A long random run follows, mostly well-formed
// traffic (adds, deletes of live timers, checks aimed at the earliest expiry)
// mixed with raw noise on every field. An in-bench timer table predicts every
// result, and results are checked in order, field by field.
module tb_ordered_timer_queue;

    localparam int FW  = otq_pkg::FW;
    localparam int TW  = otq_pkg::TW;
    localparam int DW  = otq_pkg::DW;
    localparam int IDW = otq_pkg::IDW;
    localparam int STW = otq_pkg::STW;
    localparam int SLW = otq_pkg::SLW;

    localparam int SLOTS          = 16;
    localparam int SCRIPT_ROWS    = 20;
    localparam int RANDOM_ITEMS   = 1030;
    localparam int DRAIN_CYCLES   = 2 * SLOTS + 20;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_PRINTS     = 200;

    // Operation code the block does not define; it must leave the table alone
    localparam logic [FW-1:0]  FN_SPARE  = 2'd3;
    localparam logic [TW-1:0]  MAX_TICK  = '1;
    localparam logic [DW-1:0]  MAX_DELAY = '1;
    localparam logic [IDW-1:0] MAX_ID    = '1;

    typedef struct packed {
        logic [STW-1:0] status;
        logic [IDW-1:0] timer_id;
        logic [TW-1:0]  expire_ms;
        logic [SLW-1:0] sleep_ms;
    } t_timer_result;

    // One scripted operation; a pinned row carries its result typed in
    typedef struct packed {
        logic [FW-1:0]  func;
        logic [TW-1:0]  now_ms;
        logic [DW-1:0]  delay_ms;
        logic [IDW-1:0] target_id;
        logic [TW-1:0]  target_expire;
        logic [7:0]     repeats;
        logic           pinned;
        t_timer_result  want;
    } t_script_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_stall;
    logic [FW-1:0]         i_func;
    logic [TW-1:0]         i_now_ms;
    logic [DW-1:0]         i_delay_ms;
    logic [IDW-1:0]        i_target_id;
    logic [TW-1:0]         i_target_expire;
    logic                  o_valid;
    logic                  i_stall;
    logic [STW-1:0]        o_status;
    logic [IDW-1:0]        o_timer_id;
    logic [TW-1:0]         o_expire_ms;
    logic signed [SLW-1:0] o_sleep_ms;

    ordered_timer_queue #(
        .TIMER_SLOTS(SLOTS)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_func         (i_func),
        .i_now_ms       (i_now_ms),
        .i_delay_ms     (i_delay_ms),
        .i_target_id    (i_target_id),
        .i_target_expire(i_target_expire),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_status       (o_status),
        .o_timer_id     (o_timer_id),
        .o_expire_ms    (o_expire_ms),
        .o_sleep_ms     (o_sleep_ms)
    );

    // Predicted timer table, updated at every accepted input transfer
    logic           slot_live   [SLOTS];
    logic [TW-1:0]  slot_expire [SLOTS];
    logic [IDW-1:0] slot_id     [SLOTS];
    logic [IDW-1:0] last_id;

    t_timer_result  expected_results [$];
    t_timer_result  pin_result;
    logic           pin_active;
    bit             calm;
    int             mismatches;
    int             results_seen;
    int             idle_cycles;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Earliest live timer by (expiry, id), or -1 for an empty table
    function automatic int earliest_slot();
        int best;
        best = -1;
        for (int k = 0; k < SLOTS; k++) begin
            if (slot_live[k] && (best < 0 || slot_expire[k] < slot_expire[best] ||
                (slot_expire[k] == slot_expire[best] && slot_id[k] < slot_id[best])))
                best = k;
        end
        return best;
    endfunction

    function automatic int matching_slot(input logic [TW-1:0] exp_ms,
                                         input logic [IDW-1:0] id);
        for (int k = 0; k < SLOTS; k++)
            if (slot_live[k] && slot_expire[k] == exp_ms && slot_id[k] == id)
                return k;
        return -1;
    endfunction

    // Apply one operation to the predicted table and return its result
    function automatic t_timer_result timer_step(input logic [FW-1:0] func,
                                                 input logic [TW-1:0] now,
                                                 input logic [DW-1:0] delay,
                                                 input logic [IDW-1:0] tid,
                                                 input logic [TW-1:0] texp);
        t_timer_result  r;
        logic [TW:0]    sum;
        logic [TW-1:0]  exp_ms;
        logic [IDW-1:0] id_next;
        int             free_k;
        int             k;
        r = '0;
        r.status = otq_pkg::ST_MISS;
        case (func)
            otq_pkg::FN_ADD: begin
                free_k = -1;
                for (int s = SLOTS - 1; s >= 0; s--)
                    if (!slot_live[s]) free_k = s;
                sum = {1'b0, now} + {{(TW + 1 - DW){1'b0}}, delay};
                exp_ms = sum[TW] ? MAX_TICK : sum[TW-1:0];
                id_next = last_id + 1'b1;
                if (matching_slot(exp_ms, id_next) >= 0) begin
                    // key already present: spend the id, store nothing
                    last_id = id_next;
                    r.status = otq_pkg::ST_DONE;
                    r.timer_id = id_next;
                    r.expire_ms = exp_ms;
                end else if (free_k < 0) begin
                    r.status = otq_pkg::ST_FULL;
                end else begin
                    last_id = id_next;
                    slot_live[free_k] = 1'b1;
                    slot_expire[free_k] = exp_ms;
                    slot_id[free_k] = id_next;
                    r.status = otq_pkg::ST_DONE;
                    r.timer_id = id_next;
                    r.expire_ms = exp_ms;
                end
            end
            otq_pkg::FN_DELETE: begin
                k = matching_slot(texp, tid);
                if (k >= 0) begin
                    slot_live[k] = 1'b0;
                    r.status = otq_pkg::ST_DONE;
                end
            end
            otq_pkg::FN_CHECK: begin
                k = earliest_slot();
                if (k >= 0 && slot_expire[k] <= now) begin
                    slot_live[k] = 1'b0;
                    r.status = otq_pkg::ST_DONE;
                    r.timer_id = slot_id[k];
                    r.expire_ms = slot_expire[k];
                end
            end
            default: ;
        endcase
        k = earliest_slot();
        if (k < 0)
            r.sleep_ms = otq_pkg::SLEEP_EMPTY;
        else if (slot_expire[k] > now)
            r.sleep_ms = {1'b0, slot_expire[k] - now};
        else
            r.sleep_ms = '0;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want_v);
        if (mismatches < MAX_PRINTS)
            $display("mismatch on %s at result %0d: got %h, want %h",
                     what, results_seen, got, want_v);
        mismatches++;
    endtask

    // Present one operation after a gap, hold it until the block takes it,
    // and return on the following falling edge.
    task automatic drive_item(input logic [FW-1:0] func, input logic [TW-1:0] now,
                              input logic [DW-1:0] delay, input logic [IDW-1:0] tid,
                              input logic [TW-1:0] texp, input logic pin,
                              input t_timer_result want, input int gap);
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_func = func;
        i_now_ms = now;
        i_delay_ms = delay;
        i_target_id = tid;
        i_target_expire = texp;
        pin_active = pin;
        pin_result = want;
        i_valid = 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Predict at every input transfer; a pinned row overrides the prediction
    always @(posedge i_clk) begin : input_monitor
        t_timer_result r;
        if (i_rst_n && i_valid && !o_stall) begin
            r = timer_step(i_func, i_now_ms, i_delay_ms, i_target_id, i_target_expire);
            if (pin_active) r = pin_result;
            expected_results.push_back(r);
        end
    end

    // Check every result transfer against the oldest prediction
    always @(posedge i_clk) begin : result_monitor
        t_timer_result w;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result", {62'd0, o_status}, '0);
            end else begin
                w = expected_results.pop_front();
                if (o_status != w.status)
                    report_mismatch("status", {62'd0, o_status}, {62'd0, w.status});
                if (o_timer_id != w.timer_id)
                    report_mismatch("timer_id", {32'd0, o_timer_id}, {32'd0, w.timer_id});
                if (o_expire_ms != w.expire_ms)
                    report_mismatch("expire_ms", {16'd0, o_expire_ms}, {16'd0, w.expire_ms});
                if (o_sleep_ms != w.sleep_ms)
                    report_mismatch("sleep_ms", {15'd0, o_sleep_ms}, {15'd0, w.sleep_ms});
            end
            results_seen++;
        end
    end

    // Stop a hung run: count cycles without any transfer on either side
    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout after %0d cycles without a transfer", idle_cycles);
            $display("tb_ordered_timer_queue failed");
            $finish;
        end
    end

    // Result side: once a result shows up, hold it stalled for a drawn number
    // of cycles, then take it. Calm stretches take results at once.
    initial begin : result_sink
        int hold;
        hold = 0;
        forever begin
            @(negedge i_clk);
            if (o_valid) begin
                if (hold > 0) begin
                    i_stall = 1'b1;
                    repeat (hold) @(negedge i_clk);
                    i_stall = 1'b0;
                end
                @(posedge i_clk);
                hold = calm ? 0 : $urandom_range(0, 9);
            end
        end
    end

    initial begin : stimulus
        t_script_row    script [SCRIPT_ROWS];
        int             live [$];
        int             n;
        int             k;
        int             roll;
        int             pick;
        bit             filling;
        logic [FW-1:0]  func;
        logic [TW-1:0]  now;
        logic [TW-1:0]  wall_ms;
        logic [DW-1:0]  delay;
        logic [IDW-1:0] tid;
        logic [TW-1:0]  texp;

        // Hold every input at a known value through reset
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_func = otq_pkg::FN_ADD;
        i_now_ms = '0;
        i_delay_ms = '0;
        i_target_id = '0;
        i_target_expire = '0;
        pin_active = 1'b0;
        pin_result = '0;
        calm = 1'b0;
        mismatches = 0;
        results_seen = 0;
        idle_cycles = 0;
        for (int s = 0; s < SLOTS; s++) begin
            slot_live[s] = 1'b0;
            slot_expire[s] = '0;
            slot_id[s] = '0;
        end
        last_id = '0;

        // Each row: op, now, delay, target id, target expiry, repeats, pinned, result
        script = '{
            // check and delete on the empty table, spare op with all ones
            '{otq_pkg::FN_CHECK, 48'd0, 32'd0, 32'd0, 48'd0, 8'd1, 1'b1,
              '{otq_pkg::ST_MISS, 32'd0, 48'd0, otq_pkg::SLEEP_EMPTY}},
            '{otq_pkg::FN_DELETE, 48'd0, 32'd0, MAX_ID, MAX_TICK, 8'd1, 1'b1,
              '{otq_pkg::ST_MISS, 32'd0, 48'd0, otq_pkg::SLEEP_EMPTY}},
            '{FN_SPARE, MAX_TICK, MAX_DELAY, MAX_ID, MAX_TICK, 8'd1, 1'b1,
              '{otq_pkg::ST_MISS, 32'd0, 48'd0, otq_pkg::SLEEP_EMPTY}},
            // zero delay, then check one tick early and exactly on time
            '{otq_pkg::FN_ADD, 48'd100, 32'd0, 32'd0, 48'd0, 8'd1, 1'b1,
              '{otq_pkg::ST_DONE, 32'd1, 48'd100, 49'd0}},
            '{otq_pkg::FN_CHECK, 48'd99, 32'd0, 32'd0, 48'd0, 8'd1, 1'b1,
              '{otq_pkg::ST_MISS, 32'd0, 48'd0, 49'd1}},
            '{otq_pkg::FN_CHECK, 48'd100, 32'd0, 32'd0, 48'd0, 8'd1, 1'b1,
              '{otq_pkg::ST_DONE, 32'd1, 48'd100, otq_pkg::SLEEP_EMPTY}},
            // expiry saturates at the top of the tick range
            '{otq_pkg::FN_ADD, MAX_TICK, MAX_DELAY, 32'd0, 48'd0, 8'd1, 1'b1,
              '{otq_pkg::ST_DONE, 32'd2, MAX_TICK, 49'd0}},
            '{otq_pkg::FN_ADD, 48'd0, MAX_DELAY, 32'd0, 48'd0, 8'd1, 1'b1,
              '{otq_pkg::ST_DONE, 32'd3, 48'hFFFF_FFFF, 49'hFFFF_FFFF}},
            // delete needs both keys to match
            '{otq_pkg::FN_DELETE, 48'd0, 32'd0, 32'd3, 48'hFFFF_FFFE, 8'd1, 1'b1,
              '{otq_pkg::ST_MISS, 32'd0, 48'd0, 49'hFFFF_FFFF}},
            '{otq_pkg::FN_DELETE, 48'd0, 32'd0, 32'd2, MAX_TICK, 8'd1, 1'b1,
              '{otq_pkg::ST_DONE, 32'd0, 48'd0, 49'hFFFF_FFFF}},
            '{otq_pkg::FN_DELETE, 48'd0, 32'd0, 32'd2, MAX_TICK, 8'd1, 1'b1,
              '{otq_pkg::ST_MISS, 32'd0, 48'd0, 49'hFFFF_FFFF}},
            '{FN_SPARE, 48'd0, 32'd0, 32'd0, 48'd0, 8'd1, 1'b1,
              '{otq_pkg::ST_MISS, 32'd0, 48'd0, 49'hFFFF_FFFF}},
            // fill the table with equal expiries, then add on a full table
            '{otq_pkg::FN_ADD, 48'd1000, 32'd50, 32'd0, 48'd0, 8'd15, 1'b0, '0},
            '{otq_pkg::FN_ADD, 48'd1000, 32'd5, 32'd0, 48'd0, 8'd1, 1'b1,
              '{otq_pkg::ST_FULL, 32'd0, 48'd0, 49'd50}},
            // equal expiries fire lowest id first; the full add spent no id
            '{otq_pkg::FN_CHECK, 48'd1050, 32'd0, 32'd0, 48'd0, 8'd1, 1'b1,
              '{otq_pkg::ST_DONE, 32'd4, 48'd1050, 49'd0}},
            '{otq_pkg::FN_ADD, 48'd1000, 32'd5, 32'd0, 48'd0, 8'd1, 1'b1,
              '{otq_pkg::ST_DONE, 32'd19, 48'd1005, 49'd5}},
            '{otq_pkg::FN_CHECK, 48'd2000, 32'd0, 32'd0, 48'd0, 8'd3, 1'b0, '0},
            '{otq_pkg::FN_DELETE, 48'd1050, 32'd0, 32'd10, 48'd1050, 8'd1, 1'b1,
              '{otq_pkg::ST_DONE, 32'd0, 48'd0, 49'd0}},
            // drain everything due, then check at the tick limit to fire the last timer
            '{otq_pkg::FN_CHECK, 48'hFFFF_FFFE, 32'd0, 32'd0, 48'd0, 8'd12, 1'b0, '0},
            '{otq_pkg::FN_CHECK, MAX_TICK, 32'd0, 32'd0, 48'd0, 8'd1, 1'b1,
              '{otq_pkg::ST_DONE, 32'd3, 48'hFFFF_FFFF, otq_pkg::SLEEP_EMPTY}}
        };

        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (script[r]) begin
            for (int rep = 0; rep < script[r].repeats; rep++)
                drive_item(script[r].func, script[r].now_ms, script[r].delay_ms,
                           script[r].target_id, script[r].target_expire,
                           script[r].pinned, script[r].want, $urandom_range(0, 9));
        end

        // Random traffic in alternating fill and drain phases
        wall_ms = 48'd5000;
        filling = 1'b0;
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 150 == 0) begin
                calm = ($urandom_range(0, 3) == 0);
                filling = ~filling;
            end
            wall_ms = wall_ms + TW'($urandom_range(0, filling ? 4 : 20));
            now = wall_ms;
            delay = $urandom;
            tid = $urandom;
            texp = {16'($urandom), 32'($urandom)};
            roll = $urandom_range(0, 99);
            if (roll < 8) begin
                // noise: every field fully random, spare op included
                func = 2'($urandom);
                now = {16'($urandom), 32'($urandom)};
            end else if (roll < (filling ? 60 : 35)) begin
                func = otq_pkg::FN_ADD;
                pick = $urandom_range(0, 9);
                if (pick < 7)
                    delay = $urandom_range(0, 60);
                else if (pick < 9)
                    delay = $urandom_range(0, 5000);
            end else if (roll < (filling ? 75 : 55)) begin
                // mostly hit a live timer, sometimes just miss one key
                func = otq_pkg::FN_DELETE;
                live = {};
                for (int s = 0; s < SLOTS; s++)
                    if (slot_live[s]) live.push_back(s);
                if (live.size() != 0 && $urandom_range(0, 3) != 0) begin
                    k = live[$urandom_range(0, live.size() - 1)];
                    tid = slot_id[k];
                    texp = slot_expire[k];
                    pick = $urandom_range(0, 7);
                    if (pick == 0)
                        tid = tid + 1'b1;
                    else if (pick == 1)
                        texp = texp + 1'b1;
                    else if (pick == 2)
                        texp = texp - 1'b1;
                end else begin
                    tid = last_id - IDW'($urandom_range(0, 3));
                    texp = wall_ms + TW'($urandom_range(0, 60));
                end
            end else if (roll < 97) begin
                // aim at the due boundary of the earliest timer now and then
                func = otq_pkg::FN_CHECK;
                k = earliest_slot();
                pick = $urandom_range(0, 3);
                if (k >= 0 && pick == 0)
                    now = slot_expire[k];
                else if (k >= 0 && pick == 1)
                    now = slot_expire[k] - 1'b1;
            end else begin
                func = FN_SPARE;
            end
            drive_item(func, now, delay, tid, texp, 1'b0, '0,
                       calm ? 0 : $urandom_range(0, 9));
        end
        i_valid = 1'b0;

        // Wait out the outstanding results, then watch for strays
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0)
            $display("tb_ordered_timer_queue passed");
        else
            $display("tb_ordered_timer_queue failed");
        $finish;
    end

endmodule

`default_nettype wire

[sim.f]
sv/otq_pkg.sv
sv/otq_cmp.sv
sv/otq_store.sv
sv/ordered_timer_queue.sv
test/tb_ordered_timer_queue.sv
